/* rtl/elr_pkg.sv */
`default_nettype none

package elr_pkg;

	// field widths
	localparam int RADIUS_BITS = 10;
	localparam int COORD_BITS  = 11;
	localparam int PIX_BITS    = COORD_BITS + 2;
	// accumulators never wrap at this width
	localparam int ACC_BITS    = 3 * RADIUS_BITS + 4;
	localparam int SQ_BITS     = 2 * RADIUS_BITS;
	// signed walk position, one past the semi-axis either way
	localparam int WALK_BITS   = RADIUS_BITS + 2;
	// multiplier operands and product
	localparam int MUL_A_BITS  = SQ_BITS + 1;
	localparam int MUL_B_BITS  = RADIUS_BITS + 2;
	localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;

	// command codes of the input item
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// index of the fourth mirrored pixel
	localparam logic [1:0] PIX_LAST = 2'd3;

	// multiplier jobs of the start setup
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SQ_A,
		MUL_SQ_B,
		MUL_X_DELTA,
		MUL_STOP_X,
		MUL_Y_DELTA2,
		MUL_STOP_Y2
	} mul_op_t;

	// walk update phases of a step
	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_ADVANCE,
		UPD_ADJUST,
		UPD_REGION
	} upd_op_t;

	typedef struct packed {
		logic       load_start;
		mul_op_t    mul_op;
		upd_op_t    upd_op;
		logic       load_pix;
		logic [1:0] pix_idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic walking;
	} dp_status_t;

endpackage

`default_nettype wire

/* rtl/elr_ctrl.sv */
`default_nettype none

module elr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                cmd,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire elr_pkg::dp_status_t status,
	output elr_pkg::ctl_cmd_t        ctl
);

	typedef enum logic [3:0] {
		S_WAIT,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_M5,
		S_M6,
		S_U1,
		S_U2,
		S_U3,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] pix_idx_q;
	logic       out_valid_q;
	logic       slot_free;

	assign in_stall  = (state_q != S_WAIT);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	// decode datapath commands from the state
	always_comb begin
		ctl            = '0;
		ctl.mul_op     = elr_pkg::MUL_NONE;
		ctl.upd_op     = elr_pkg::UPD_NONE;
		ctl.pix_idx    = pix_idx_q;
		case (state_q)
			S_WAIT: ctl.load_start = in_valid && (cmd == elr_pkg::CMD_START);
			S_M1:   ctl.mul_op = elr_pkg::MUL_SQ_A;
			S_M2:   ctl.mul_op = elr_pkg::MUL_SQ_B;
			S_M3:   ctl.mul_op = elr_pkg::MUL_X_DELTA;
			S_M4:   ctl.mul_op = elr_pkg::MUL_STOP_X;
			S_M5:   ctl.mul_op = elr_pkg::MUL_Y_DELTA2;
			S_M6:   ctl.mul_op = elr_pkg::MUL_STOP_Y2;
			S_U1:   ctl.upd_op = elr_pkg::UPD_ADVANCE;
			S_U2:   ctl.upd_op = elr_pkg::UPD_ADJUST;
			S_U3:   ctl.upd_op = elr_pkg::UPD_REGION;
			S_EMIT: ctl.load_pix = slot_free;
			default: ;
		endcase
	end

	// sequence setup, walk update and pixel output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WAIT;
			pix_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_WAIT: begin
					pix_idx_q <= '0;
					if (in_valid) begin
						if (cmd == elr_pkg::CMD_START) state_q <= S_M1;
						else if (status.walking) state_q <= S_U1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: state_q <= S_M6;
				S_M6: state_q <= S_WAIT;
				S_U1: state_q <= S_U2;
				S_U2: state_q <= S_U3;
				S_U3: state_q <= S_EMIT;
				S_EMIT: begin
					if (slot_free) begin
						pix_idx_q <= pix_idx_q + 2'd1;
						if (pix_idx_q == elr_pkg::PIX_LAST) state_q <= S_WAIT;
					end
				end
				default: state_q <= S_WAIT;
			endcase
			// raise valid on each pixel load, drop it once the transfer is taken
			if (ctl.load_pix) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/elr_dpath.sv */
`default_nettype none

module elr_dpath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire elr_pkg::ctl_cmd_t                     ctl,
	output elr_pkg::dp_status_t                        status,
	input  wire logic [elr_pkg::COORD_BITS-1:0]        center_x,
	input  wire logic [elr_pkg::COORD_BITS-1:0]        center_y,
	input  wire logic [elr_pkg::RADIUS_BITS-1:0]       radius_x,
	input  wire logic [elr_pkg::RADIUS_BITS-1:0]       radius_y,
	output logic signed [elr_pkg::PIX_BITS-1:0]        pixel_x,
	output logic signed [elr_pkg::PIX_BITS-1:0]        pixel_y,
	output logic                                       last_of_step,
	output logic                                       ellipse_done
);

	localparam int R   = elr_pkg::RADIUS_BITS;
	localparam int C   = elr_pkg::COORD_BITS;
	localparam int A   = elr_pkg::ACC_BITS;
	localparam int W   = elr_pkg::WALK_BITS;
	localparam int P   = elr_pkg::PIX_BITS;
	localparam int SQ  = elr_pkg::SQ_BITS;
	localparam int TW  = A + 2;
	localparam int SUM = ((P > W) ? P : W) + 1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ONE,
		PH_TWO,
		PH_DONE
	} phase_t;

	phase_t                          phase_q;
	logic                            done_q;
	logic [C-1:0]                    center_col_q, center_row_q;
	logic [R-1:0]                    semi_a_q, semi_b_q;
	logic [SQ-1:0]                   sq_a_q, sq_b_q;
	logic signed [A-1:0]             x_delta_q, y_delta_q, err_q;
	logic signed [A-1:0]             stop_x_q, stop_y_q;
	logic signed [A-1:0]             y_delta2_q, stop_y2_q;
	logic signed [W-1:0]             walk_x_q, walk_y_q, pos_x_q, pos_y_q;
	logic signed [P-1:0]             pixel_x_q, pixel_y_q;
	logic                            last_q, pix_done_q;

	logic signed [elr_pkg::MUL_A_BITS-1:0] mul_a;
	logic signed [elr_pkg::MUL_B_BITS-1:0] mul_b;
	logic signed [elr_pkg::PROD_BITS-1:0]  prod;
	logic signed [A-1:0]             prod_acc, prod_dbl;
	logic signed [A-1:0]             twice_a, twice_b, sq_b_acc;
	logic signed [TW-1:0]            test_x, test_y;
	logic                            adj_x, adj_y;
	logic [SUM-1:0]                  cx_ext, cy_ext, px_ext, py_ext;
	logic [SUM-1:0]                  sum_x, sum_y;

	assign status.walking = (phase_q == PH_ONE) || (phase_q == PH_TWO);

	// select multiplier operands for each setup job
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.mul_op)
			elr_pkg::MUL_SQ_A: begin
				mul_a = $signed(elr_pkg::MUL_A_BITS'(semi_a_q));
				mul_b = $signed(elr_pkg::MUL_B_BITS'(semi_a_q));
			end
			elr_pkg::MUL_SQ_B: begin
				mul_a = $signed(elr_pkg::MUL_A_BITS'(semi_b_q));
				mul_b = $signed(elr_pkg::MUL_B_BITS'(semi_b_q));
			end
			elr_pkg::MUL_X_DELTA: begin
				mul_a = $signed(elr_pkg::MUL_A_BITS'(sq_b_q));
				mul_b = $signed(elr_pkg::MUL_B_BITS'(1) - {1'b0, semi_a_q, 1'b0});
			end
			elr_pkg::MUL_STOP_X: begin
				mul_a = $signed(elr_pkg::MUL_A_BITS'(sq_b_q));
				mul_b = $signed(elr_pkg::MUL_B_BITS'(semi_a_q));
			end
			elr_pkg::MUL_Y_DELTA2: begin
				mul_a = $signed(elr_pkg::MUL_A_BITS'(sq_a_q));
				mul_b = $signed(elr_pkg::MUL_B_BITS'(1) - {1'b0, semi_b_q, 1'b0});
			end
			elr_pkg::MUL_STOP_Y2: begin
				mul_a = $signed(elr_pkg::MUL_A_BITS'(sq_a_q));
				mul_b = $signed(elr_pkg::MUL_B_BITS'(semi_b_q));
			end
			default: ;
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_acc = A'(prod);
	assign prod_dbl = $signed(A'({prod, 1'b0}));

	assign twice_a  = $signed(A'({sq_a_q, 1'b0}));
	assign twice_b  = $signed(A'({sq_b_q, 1'b0}));
	assign sq_b_acc = $signed(A'(sq_b_q));

	// midpoint tests 2*err + delta > 0
	assign test_x = ($signed({{2{err_q[A-1]}}, err_q}) <<< 1)
	              + $signed({{2{x_delta_q[A-1]}}, x_delta_q});
	assign test_y = ($signed({{2{err_q[A-1]}}, err_q}) <<< 1)
	              + $signed({{2{y_delta_q[A-1]}}, y_delta_q});
	assign adj_x  = !test_x[TW-1] && (test_x != '0);
	assign adj_y  = !test_y[TW-1] && (test_y != '0);

	// mirror the captured position about the center
	assign cx_ext = {{(SUM-C){1'b0}}, center_col_q};
	assign cy_ext = {{(SUM-C){1'b0}}, center_row_q};
	assign px_ext = {{(SUM-W){pos_x_q[W-1]}}, pos_x_q};
	assign py_ext = {{(SUM-W){pos_y_q[W-1]}}, pos_y_q};
	assign sum_x  = ctl.pix_idx[0] ? (cx_ext - px_ext) : (cx_ext + px_ext);
	assign sum_y  = (ctl.pix_idx[0] ^ ctl.pix_idx[1]) ? (cy_ext - py_ext)
	                                                   : (cy_ext + py_ext);

	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign last_of_step = last_q;
	assign ellipse_done = pix_done_q;

	// hold walk phase and final-step flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			if (ctl.load_start) begin
				phase_q <= PH_ONE;
			end else if (ctl.upd_op == elr_pkg::UPD_ADVANCE) begin
				done_q <= 1'b0;
			end else if (ctl.upd_op == elr_pkg::UPD_REGION) begin
				if (phase_q == PH_ONE) begin
					if ((stop_x_q < stop_y_q) || (sq_a_q == '0)) phase_q <= PH_TWO;
				end else if ((stop_x_q > stop_y_q) || (sq_b_q == '0)) begin
					phase_q <= PH_DONE;
					done_q  <= 1'b1;
				end
			end
		end
	end

	// load setup, advance the error walk, register output pixels
	always_ff @(posedge clk) begin
		if (ctl.load_start) begin
			center_col_q <= center_x;
			center_row_q <= center_y;
			semi_a_q     <= radius_x;
			semi_b_q     <= radius_y;
			walk_x_q     <= $signed(W'(radius_x));
			walk_y_q     <= '0;
			err_q        <= '0;
			stop_y_q     <= '0;
		end
		case (ctl.mul_op)
			elr_pkg::MUL_SQ_A: begin
				sq_a_q    <= prod[SQ-1:0];
				y_delta_q <= prod_acc;
			end
			elr_pkg::MUL_SQ_B:     sq_b_q     <= prod[SQ-1:0];
			elr_pkg::MUL_X_DELTA:  x_delta_q  <= prod_acc;
			elr_pkg::MUL_STOP_X:   stop_x_q   <= prod_dbl;
			elr_pkg::MUL_Y_DELTA2: y_delta2_q <= prod_acc;
			elr_pkg::MUL_STOP_Y2:  stop_y2_q  <= prod_dbl;
			default: ;
		endcase
		case (ctl.upd_op)
			elr_pkg::UPD_ADVANCE: begin
				pos_x_q <= walk_x_q;
				pos_y_q <= walk_y_q;
				if (phase_q == PH_ONE) begin
					walk_y_q  <= walk_y_q + W'(1);
					stop_y_q  <= stop_y_q + twice_a;
					err_q     <= err_q + y_delta_q;
					y_delta_q <= y_delta_q + twice_a;
				end else begin
					walk_x_q  <= walk_x_q + W'(1);
					stop_x_q  <= stop_x_q + twice_b;
					err_q     <= err_q + x_delta_q;
					x_delta_q <= x_delta_q + twice_b;
				end
			end
			elr_pkg::UPD_ADJUST: begin
				if (phase_q == PH_ONE) begin
					if (adj_x) begin
						walk_x_q  <= walk_x_q - W'(1);
						stop_x_q  <= stop_x_q - twice_b;
						err_q     <= err_q + x_delta_q;
						x_delta_q <= x_delta_q + twice_b;
					end
				end else if (adj_y) begin
					walk_y_q  <= walk_y_q - W'(1);
					stop_y_q  <= stop_y_q - twice_a;
					err_q     <= err_q + y_delta_q;
					y_delta_q <= y_delta_q + twice_a;
				end
			end
			elr_pkg::UPD_REGION: begin
				if ((phase_q == PH_ONE) && ((stop_x_q < stop_y_q) || (sq_a_q == '0))) begin
					walk_x_q  <= '0;
					walk_y_q  <= $signed(W'(semi_b_q));
					x_delta_q <= sq_b_acc;
					y_delta_q <= y_delta2_q;
					err_q     <= '0;
					stop_x_q  <= '0;
					stop_y_q  <= stop_y2_q;
				end
			end
			default: ;
		endcase
		if (ctl.load_pix) begin
			pixel_x_q  <= $signed(sum_x[P-1:0]);
			pixel_y_q  <= $signed(sum_y[P-1:0]);
			last_q     <= (ctl.pix_idx == elr_pkg::PIX_LAST);
			pix_done_q <= done_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/ellipse_rasterizer.sv */
// Start item: accepted, then six setup steps on the shared
//   multiplier (one product per cycle); the input stalls until setup ends.
// Step item: three walk-update steps, then four pixels through one output
//   register; the input stalls until the last pixel is loaded, and
//   back-pressure holds each pixel. Steps while idle or done give no pixels.
// Reset (arst_n low, asynchronous) returns the block to idle with no output.
`default_nettype none

module ellipse_rasterizer (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  cmd,
	input  wire logic [elr_pkg::COORD_BITS-1:0]        center_x,
	input  wire logic [elr_pkg::COORD_BITS-1:0]        center_y,
	input  wire logic [elr_pkg::RADIUS_BITS-1:0]       radius_x,
	input  wire logic [elr_pkg::RADIUS_BITS-1:0]       radius_y,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [elr_pkg::PIX_BITS-1:0]        pixel_x,
	output logic signed [elr_pkg::PIX_BITS-1:0]        pixel_y,
	output logic                                       last_of_step,
	output logic                                       ellipse_done
);

	elr_pkg::ctl_cmd_t   ctl;
	elr_pkg::dp_status_t status;

	elr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.ctl       (ctl)
	);

	elr_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.status       (status),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius_x     (radius_x),
		.radius_y     (radius_y),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_of_step (last_of_step),
		.ellipse_done (ellipse_done)
	);

	// a start transfer always enters setup
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == elr_pkg::CMD_START) |=> in_stall)
		else $error("start transfer did not enter setup");

	// no new item while a step still has pixels to give
	a_step_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_step |-> in_stall)
		else $error("input open in the middle of a step");

	// the done flag is the same on all four pixels of a step
	a_done_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_step |=> ellipse_done == $past(ellipse_done))
		else $error("done flag changed within a step");

endmodule

`default_nettype wire
